/* rtl/core/adfc_pkg.sv */
package adfc_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned DvdW     = 64;
  localparam int unsigned DsrW     = 34;

  localparam logic [31:0] StatusBusy   = 32'h4000_0000;
  localparam logic [31:0] StatusFull   = 32'h8000_0000;
  localparam logic [31:0] DefaultRate  = 32'd44100;
  localparam logic [31:0] DefaultBits  = 32'd16;
  localparam logic [31:0] SatValue     = 32'hFFFF_FFFF;

  localparam logic [31:0] VideoClockReset = 32'd48681812;
  localparam logic [31:0] CountsReset     = 32'd46875000;

  localparam logic [1:0] ModeRead  = 2'd0;
  localparam logic [1:0] ModeWrite = 2'd1;
  localparam logic [1:0] ModeTick  = 2'd2;

  localparam logic [2:0] RegDram   = 3'd0;
  localparam logic [2:0] RegLength = 3'd1;
  localparam logic [2:0] RegCtrl   = 3'd2;
  localparam logic [2:0] RegStatus = 3'd3;
  localparam logic [2:0] RegDac    = 3'd4;
  localparam logic [2:0] RegBits   = 3'd5;

  localparam logic CfgVideoClock = 1'b0;
  localparam logic CfgCounts     = 1'b1;

  typedef enum logic [1:0] {
    JOB_LEN  = 2'd0,
    JOB_PUSH = 2'd1,
    JOB_POP  = 2'd2
  } job_t;

  typedef struct packed {
    logic            go;
    logic [DvdW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

  function automatic logic [31:0] mwrite(input logic [31:0] old, input logic [31:0] v,
                                         input logic [31:0] m);
    return (old & ~m) | (v & m);
  endfunction

  function automatic logic [31:0] sat32(input logic [DvdW-1:0] q);
    return (q[DvdW-1:32] != '0) ? SatValue : q[31:0];
  endfunction

endpackage

/* rtl/core/adfc_div.sv */
// Restoring divider, one quotient bit per cycle.
module adfc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  adfc_pkg::div_req_t       req,
  output logic                     done,
  output logic [adfc_pkg::DvdW-1:0] quotient
);
  localparam int unsigned CntW = $clog2(adfc_pkg::DvdW);

  logic                      busy;
  logic [CntW-1:0]           cnt;
  logic [adfc_pkg::DsrW-1:0] rem;
  logic [adfc_pkg::DsrW-1:0] dsr;
  logic [adfc_pkg::DvdW-1:0] dvd;
  logic [adfc_pkg::DsrW:0]   shifted;
  logic [adfc_pkg::DsrW+1:0] diff;
  logic                      ge;

  assign shifted  = {rem, dvd[adfc_pkg::DvdW-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dsr};
  assign ge       = ~diff[adfc_pkg::DsrW+1];
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(adfc_pkg::DvdW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[adfc_pkg::DsrW-1:0] : shifted[adfc_pkg::DsrW-1:0];
      dvd <= {dvd[adfc_pkg::DvdW-2:0], ge};
    end
  end
endmodule

/* rtl/core/audio_dma_fifo_controller.sv */
// Audio DMA interface with a two-entry request queue.
// Input channel (in_valid/in_ready): one beat is a register read, a masked
// register write or one CPU count tick (mode, reg_index, write_data,
// write_mask). Output channel (out_valid/out_ready): exactly one result beat
// per input beat, in order: read data, interrupt raise/clear, DMA start with
// address and length, and the sample format when it changes.
// Configuration port (cfg_wen/cfg_addr/cfg_wdata): index 0 video clock,
// index 1 count ticks per second; write only while the block is idle.
// A length write runs the shared 64-bit divider for the sample rate and,
// if that is nonzero, a multiply and a second divide for the duration; a
// length read while a countdown runs takes one multiply and one divide; a
// tick that pops the queue takes one divide. Plain register accesses and
// other ticks do not use the divider. The shared restoring divider works
// one quotient bit per cycle. One beat is worked at a time; in_ready is low
// from accept until the result is handed over.
// A finished result sits in the output register; the next input beat is
// accepted while it waits. If the receiver stalls, the following result
// holds in the sequencer until the output register frees.
// Reset clears the register file, the queue and the countdown, and restores the
// configuration defaults.
module audio_dma_fifo_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [2:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [31:0] write_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        irq_raise,
  output logic        irq_clear,
  output logic        dma_start,
  output logic [31:0] dma_address,
  output logic [31:0] dma_length,
  output logic        format_update,
  output logic [31:0] sample_rate,
  output logic [31:0] sample_bits
);
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_RATE   = 6'b000100,
    S_MUL    = 6'b001000,
    S_QUO    = 6'b010000,
    S_HEAD   = 6'b100000
  } state_t;

  state_t           state;
  logic             out_pend;
  adfc_pkg::job_t   job;

  logic [31:0] vclk, cps;
  logic [31:0] dram, len, ctl, dac, bitr;
  logic        busy, full, dirty;
  logic [31:0] qa [2];
  logic [31:0] ql [2];
  logic [31:0] qd [2];
  logic [31:0] cd;
  logic [31:0] rate, dur;
  logic [31:0] mul_a, mul_b;

  logic [1:0]  i_mode;
  logic [2:0]  i_reg;
  logic [31:0] i_data, i_mask;

  logic [31:0] r_read, r_addr, r_len, r_srate, r_sbits;
  logic        r_raise, r_clear, r_start, r_fmt;

  adfc_pkg::div_req_t            div_req;
  logic                          div_done;
  logic [adfc_pkg::DvdW-1:0]     quo;
  logic [31:0]                   quo_sat;
  logic [31:0]                   h_addr, h_len, h_dur;
  logic                          out_free;

  adfc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quo)
  );

  // Hold off new beats while a finished result still waits for the output register.
  assign in_ready = (state == S_IDLE) && !out_pend;
  assign quo_sat  = adfc_pkg::sat32(quo);
  assign out_free = ~out_valid | out_ready;

  // Head of queue to start: a fresh push starts from the staged request,
  // a pop from slot 0 which already holds the promoted entry.
  always_comb begin
    if (job == adfc_pkg::JOB_PUSH) begin
      h_addr = dram;
      h_len  = len;
      h_dur  = dur;
    end else begin
      h_addr = qa[0];
      h_len  = ql[0];
      h_dur  = qd[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_wen) begin
      unique case (cfg_addr)
        adfc_pkg::CfgVideoClock: vclk <= cfg_wdata;
        adfc_pkg::CfgCounts:     cps  <= cfg_wdata;
        default: ;
      endcase
    end
    if (rst) begin
      vclk <= adfc_pkg::VideoClockReset;
      cps  <= adfc_pkg::CountsReset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_pend <= 1'b0;
      div_req  <= '0;
      dram <= '0; len <= '0; ctl <= '0; dac <= '0; bitr <= '0;
      busy <= 1'b0; full <= 1'b0; dirty <= 1'b0; cd <= '0;
      qa[0] <= '0; qa[1] <= '0; ql[0] <= '0; ql[1] <= '0; qd[0] <= '0; qd[1] <= '0;
      job  <= adfc_pkg::JOB_LEN;
    end else begin
      div_req.go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !out_pend) begin
            i_mode  <= mode;
            i_reg   <= reg_index;
            i_data  <= write_data;
            i_mask  <= write_mask;
            r_read  <= '0; r_addr <= '0; r_len <= '0; r_srate <= '0; r_sbits <= '0;
            r_raise <= 1'b0; r_clear <= 1'b0; r_start <= 1'b0; r_fmt <= 1'b0;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          out_pend <= 1'b1;
          state    <= S_IDLE;
          case (i_mode)
            adfc_pkg::ModeRead: begin
              case (i_reg)
                adfc_pkg::RegDram:   r_read <= dram;
                adfc_pkg::RegLength: begin
                  if (qd[0] != '0 && cd != '0) begin
                    mul_a    <= cd;
                    mul_b    <= ql[0];
                    job      <= adfc_pkg::JOB_LEN;
                    out_pend <= 1'b0;
                    state    <= S_MUL;
                  end
                end
                adfc_pkg::RegCtrl:   r_read <= ctl;
                adfc_pkg::RegStatus: r_read <= (busy ? adfc_pkg::StatusBusy : '0) |
                                               (full ? adfc_pkg::StatusFull : '0);
                adfc_pkg::RegDac:    r_read <= dac;
                adfc_pkg::RegBits:   r_read <= bitr;
                default: ;
              endcase
            end
            adfc_pkg::ModeWrite: begin
              case (i_reg)
                adfc_pkg::RegDram: dram <= adfc_pkg::mwrite(dram, i_data, i_mask);
                adfc_pkg::RegLength: begin
                  len              <= adfc_pkg::mwrite(len, i_data, i_mask);
                  job              <= adfc_pkg::JOB_PUSH;
                  div_req.go       <= 1'b1;
                  div_req.dividend <= {32'd0, vclk};
                  div_req.divisor  <= {1'b0, {1'b0, dac} + 33'd1};
                  out_pend         <= 1'b0;
                  state            <= S_RATE;
                end
                adfc_pkg::RegCtrl:   ctl <= adfc_pkg::mwrite(ctl, i_data, i_mask);
                adfc_pkg::RegStatus: r_clear <= 1'b1;
                adfc_pkg::RegDac: begin
                  if (dac != (i_data & i_mask)) dirty <= 1'b1;
                  dac <= adfc_pkg::mwrite(dac, i_data, i_mask);
                end
                adfc_pkg::RegBits: begin
                  if (bitr != (i_data & i_mask)) dirty <= 1'b1;
                  bitr <= adfc_pkg::mwrite(bitr, i_data, i_mask);
                end
                default: ;
              endcase
            end
            adfc_pkg::ModeTick: begin
              if (cd != '0) begin
                cd <= cd - 32'd1;
                if (cd == 32'd1) begin
                  r_raise <= 1'b1;
                  if (full) begin
                    // Promote slot 1 and fetch the sample rate for its start.
                    qa[0] <= qa[1];
                    ql[0] <= ql[1];
                    qd[0] <= qd[1];
                    full  <= 1'b0;
                    job   <= adfc_pkg::JOB_POP;
                    div_req.go       <= 1'b1;
                    div_req.dividend <= {32'd0, vclk};
                    div_req.divisor  <= {1'b0, {1'b0, dac} + 33'd1};
                    out_pend <= 1'b0;
                    state    <= S_RATE;
                  end else begin
                    busy <= 1'b0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        S_RATE: begin
          if (div_done) begin
            rate <= quo[31:0];
            if (job == adfc_pkg::JOB_PUSH && quo[31:0] != '0) begin
              mul_a <= len;
              mul_b <= cps;
              state <= S_MUL;
            end else begin
              dur   <= adfc_pkg::SatValue;
              state <= S_HEAD;
            end
          end
        end
        S_MUL: begin
          div_req.go       <= 1'b1;
          div_req.dividend <= mul_a * mul_b;
          div_req.divisor  <= (job == adfc_pkg::JOB_LEN) ? {2'b00, qd[0]} : {rate, 2'b00};
          state            <= S_QUO;
        end
        S_QUO: begin
          if (div_done) begin
            if (job == adfc_pkg::JOB_LEN) begin
              r_read   <= quo_sat;
              out_pend <= 1'b1;
              state    <= S_IDLE;
            end else begin
              dur   <= quo_sat;
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          out_pend <= 1'b1;
          state    <= S_IDLE;
          if (job == adfc_pkg::JOB_PUSH && busy) begin
            qa[1] <= dram;
            ql[1] <= len;
            qd[1] <= dur;
            full  <= 1'b1;
          end else begin
            if (job == adfc_pkg::JOB_PUSH) begin
              qa[0] <= dram;
              ql[0] <= len;
              qd[0] <= dur;
              busy  <= 1'b1;
            end
            r_start <= 1'b1;
            r_addr  <= h_addr;
            r_len   <= h_len;
            cd      <= (h_dur == '0) ? 32'd1 : h_dur;
            if (dirty) begin
              r_fmt   <= 1'b1;
              r_srate <= (dac == '0) ? adfc_pkg::DefaultRate : rate;
              r_sbits <= (bitr == '0) ? adfc_pkg::DefaultBits : bitr + 32'd1;
              dirty   <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // Hand the finished result to the output register when it frees.
      if (out_pend && out_free) out_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_pend && out_free) begin
      out_valid     <= 1'b1;
      read_data     <= r_read;
      irq_raise     <= r_raise;
      irq_clear     <= r_clear;
      dma_start     <= r_start;
      dma_address   <= r_addr;
      dma_length    <= r_len;
      format_update <= r_fmt;
      sample_rate   <= r_srate;
      sample_bits   <= r_sbits;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
endmodule

/* rtl/core/adfc_checker.sv */
module adfc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic irq_raise,
  input logic irq_clear,
  input logic dma_start,
  input logic format_update
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is in work");

  a_irq_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(irq_raise && irq_clear))
    else $error("interrupt raised and cleared by one beat");

  a_fmt_with_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && format_update |-> dma_start)
    else $error("format update without DMA start");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");
endmodule

bind audio_dma_fifo_controller adfc_checker u_adfc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .irq_raise     (irq_raise),
  .irq_clear     (irq_clear),
  .dma_start     (dma_start),
  .format_update (format_update)
);

/* sim/audio_dma_fifo_controller_tb.sv */
`timescale 1ns / 100ps

module audio_dma_fifo_controller_tb;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] write_mask;
  } access_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_raise;
    logic        irq_clear;
    logic        dma_start;
    logic [31:0] dma_address;
    logic [31:0] dma_length;
    logic        format_update;
    logic [31:0] sample_rate;
    logic [31:0] sample_bits;
  } outcome_t;

  localparam int WatchdogLimit = 20000;
  localparam logic [2:0] RegSpare = 3'd6;
  localparam logic [1:0] ModeSpare = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic        cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [2:0]  reg_index;
  logic [31:0] write_data;
  logic [31:0] write_mask;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] read_data;
  logic        irq_raise;
  logic        irq_clear;
  logic        dma_start;
  logic [31:0] dma_address;
  logic [31:0] dma_length;
  logic        format_update;
  logic [31:0] sample_rate;
  logic [31:0] sample_bits;

  audio_dma_fifo_controller u_top (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .reg_index(reg_index), .write_data(write_data), .write_mask(write_mask),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .irq_raise(irq_raise), .irq_clear(irq_clear),
    .dma_start(dma_start), .dma_address(dma_address), .dma_length(dma_length),
    .format_update(format_update), .sample_rate(sample_rate), .sample_bits(sample_bits)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Shadow of the block: configuration, registers, request queue, countdown.
  logic [31:0] sh_vclk, sh_cps;
  logic [31:0] sh_dram, sh_len, sh_ctrl, sh_dac, sh_bits;
  logic        sh_busy, sh_full, sh_dirty;
  logic [31:0] sh_qaddr [2];
  logic [31:0] sh_qlen  [2];
  logic [31:0] sh_qdur  [2];
  logic [31:0] sh_cnt;

  access_t  access_q[$];    // beats waiting for the driver
  outcome_t outcome_q[$];   // predicted result beats, oldest first

  int  n_fail, n_results, n_starts, n_irqs;
  bit  burst_mode;          // no drawn gaps on either side while set
  bit  long_hold_req;
  bit  in_acc;
  int  send_gap, recv_gap, hold_cnt, quiet_cycles;

  function automatic logic [63:0] rate_now();
    return {32'd0, sh_vclk} / ({32'd0, sh_dac} + 64'd1);
  endfunction

  function automatic logic [31:0] sat_to_32(input logic [63:0] q);
    return (q[63:32] != 0) ? adfc_pkg::SatValue : q[31:0];
  endfunction

  function automatic logic [31:0] duration_now();
    logic [63:0] div;
    div = 64'd4 * rate_now();
    if (div == 0) return adfc_pkg::SatValue;
    return sat_to_32(({32'd0, sh_len} * {32'd0, sh_cps}) / div);
  endfunction

  task automatic launch_head(inout outcome_t o);
    if (sh_dirty) begin
      o.format_update = 1'b1;
      o.sample_rate = (sh_dac == 0) ? adfc_pkg::DefaultRate : 32'(rate_now());
      o.sample_bits = (sh_bits == 0) ? adfc_pkg::DefaultBits : sh_bits + 32'd1;
      sh_dirty = 1'b0;
    end
    o.dma_start = 1'b1;
    o.dma_address = sh_qaddr[0];
    o.dma_length = sh_qlen[0];
    sh_cnt = (sh_qdur[0] == 0) ? 32'd1 : sh_qdur[0];
    n_starts++;
  endtask

  // Work out the result of one accepted beat and advance the shadow state.
  task automatic predict_access(input access_t a, output outcome_t o);
    logic [31:0] d;
    o = '0;
    case (a.mode)
      adfc_pkg::ModeRead: begin
        case (a.reg_index)
          adfc_pkg::RegDram:   o.read_data = sh_dram;
          adfc_pkg::RegLength: o.read_data = (sh_qdur[0] == 0 || sh_cnt == 0) ? 32'd0 :
                       sat_to_32(({32'd0, sh_cnt} * {32'd0, sh_qlen[0]}) / sh_qdur[0]);
          adfc_pkg::RegCtrl:   o.read_data = sh_ctrl;
          adfc_pkg::RegStatus: o.read_data = (sh_busy ? adfc_pkg::StatusBusy : 32'd0) |
                                             (sh_full ? adfc_pkg::StatusFull : 32'd0);
          adfc_pkg::RegDac:    o.read_data = sh_dac;
          adfc_pkg::RegBits:   o.read_data = sh_bits;
          default:             o.read_data = 32'd0;
        endcase
      end
      adfc_pkg::ModeWrite: begin
        case (a.reg_index)
          adfc_pkg::RegDram:
            sh_dram = (sh_dram & ~a.write_mask) | (a.write_data & a.write_mask);
          adfc_pkg::RegLength: begin
            sh_len = (sh_len & ~a.write_mask) | (a.write_data & a.write_mask);
            d = duration_now();
            if (sh_busy) begin
              // park in the second slot, overwriting any earlier one
              sh_qaddr[1] = sh_dram; sh_qlen[1] = sh_len; sh_qdur[1] = d;
              sh_full = 1'b1;
            end else begin
              sh_qaddr[0] = sh_dram; sh_qlen[0] = sh_len; sh_qdur[0] = d;
              sh_busy = 1'b1;
              launch_head(o);
            end
          end
          adfc_pkg::RegCtrl:
            sh_ctrl = (sh_ctrl & ~a.write_mask) | (a.write_data & a.write_mask);
          adfc_pkg::RegStatus: o.irq_clear = 1'b1;
          adfc_pkg::RegDac: begin
            if (sh_dac != (a.write_data & a.write_mask)) sh_dirty = 1'b1;
            sh_dac = (sh_dac & ~a.write_mask) | (a.write_data & a.write_mask);
          end
          adfc_pkg::RegBits: begin
            if (sh_bits != (a.write_data & a.write_mask)) sh_dirty = 1'b1;
            sh_bits = (sh_bits & ~a.write_mask) | (a.write_data & a.write_mask);
          end
          default: ;
        endcase
      end
      adfc_pkg::ModeTick: begin
        if (sh_cnt != 0) begin
          sh_cnt = sh_cnt - 32'd1;
          if (sh_cnt == 0) begin
            if (sh_full) begin
              sh_qaddr[0] = sh_qaddr[1]; sh_qlen[0] = sh_qlen[1]; sh_qdur[0] = sh_qdur[1];
              sh_full = 1'b0;
              launch_head(o);
            end else begin
              sh_busy = 1'b0;
            end
            o.irq_raise = 1'b1;
            n_irqs++;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Monitor: compare delivered beats first, then predict the newly accepted one.
  always @(posedge clk) begin
    outcome_t e, p;
    in_acc <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual read_data %h",
                   $time, read_data);
          n_fail++;
        end else begin
          e = outcome_q.pop_front();
          check_field("read_data", e.read_data, read_data);
          check_field("irq_raise", 32'(e.irq_raise), 32'(irq_raise));
          check_field("irq_clear", 32'(e.irq_clear), 32'(irq_clear));
          check_field("dma_start", 32'(e.dma_start), 32'(dma_start));
          check_field("dma_address", e.dma_address, dma_address);
          check_field("dma_length", e.dma_length, dma_length);
          check_field("format_update", 32'(e.format_update), 32'(format_update));
          check_field("sample_rate", e.sample_rate, sample_rate);
          check_field("sample_bits", e.sample_bits, sample_bits);
        end
      end
      if (in_valid && in_ready) begin
        predict_access({mode, reg_index, write_data, write_mask}, p);
        outcome_q.push_back(p);
      end
      // watchdog: count stuck cycles only while work is outstanding
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (outcome_q.size() == 0 && !in_valid))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 outcome_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Driver: hold the beat until accepted, then idle for a drawn gap.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_acc) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (access_q.size() != 0) begin
      {mode, reg_index, write_data, write_mask} <= access_q.pop_front();
      in_valid <= 1'b1;
      send_gap <= burst_mode ? 0 : $urandom_range(0, 13);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls per beat, plus one long hold on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
      recv_gap <= 0;
    end else if (long_hold_req && hold_cnt == 0 && out_ready) begin
      hold_cnt <= 600;
      long_hold_req <= 1'b0;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      // beat just taken: draw the stall before the next one
      recv_gap <= burst_mode ? 0 : $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_access(input logic [1:0] m, input logic [2:0] r,
                              input logic [31:0] v, input logic [31:0] k);
    access_q.push_back({m, r, v, k});
  endtask

  task automatic wait_drained();
    while (access_q.size() != 0 || in_valid || outcome_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_config(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (idx == adfc_pkg::CfgVideoClock) sh_vclk = val; else sh_cps = val;
  endtask

  // Let the running transfer and any parked one finish before retuning, if under 3000 ticks are needed.
  task automatic flush_transfers();
    longint unsigned n;
    wait_drained();
    n = longint'(sh_cnt) + (sh_full ? longint'(sh_qdur[1]) : 0) + 2;
    if (sh_cnt != 0 && n < 3000) begin
      repeat (n) queue_access(adfc_pkg::ModeTick, adfc_pkg::RegDram, $urandom, $urandom);
      wait_drained();
    end
  endtask

  // Well-formed transfer: address, maybe new format, length, then ticks, reads and status writes.
  task automatic queue_transfer(input bit wide);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegDram, $urandom,
                 ($urandom_range(0, 3) == 0) ? $urandom : '1);
    if ($urandom_range(0, 3) == 0)
      queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegDac,
                   wide ? $urandom : $urandom_range(0, 7), '1);
    if ($urandom_range(0, 3) == 0)
      queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegBits, $urandom,
                   ($urandom_range(0, 1) == 1) ? $urandom : '1);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegLength,
                 wide ? $urandom : $urandom_range(0, 24), '1);
    repeat ($urandom_range(0, 12)) begin
      if ($urandom_range(0, 4) == 0)
        queue_access(adfc_pkg::ModeRead, 3'($urandom_range(0, 7)), $urandom, $urandom);
      else if ($urandom_range(0, 9) == 0)
        queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegStatus, $urandom, $urandom);
      else
        queue_access(adfc_pkg::ModeTick, 3'($urandom_range(0, 7)), $urandom, $urandom);
    end
  endtask

  task automatic queue_noise(input bit wide);
    logic [1:0]  m;
    logic [2:0]  r;
    logic [31:0] v;
    m = 2'($urandom_range(0, 3));
    r = 3'($urandom_range(0, 7));
    v = $urandom;
    // keep lengths and dac rates modest so transfers still complete
    if (!wide && m == adfc_pkg::ModeWrite &&
        (r == adfc_pkg::RegLength || r == adfc_pkg::RegDac)) v = v & 32'h1F;
    queue_access(m, r, v, $urandom);
  endtask

  task automatic run_random(input int beats, input bit wide);
    int stop_at;
    stop_at = access_q.size() + beats;
    while (access_q.size() < stop_at) begin
      if ($urandom_range(0, 3) != 0) queue_transfer(wide);
      else queue_noise(wide);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0; cfg_addr = 1'b0; cfg_wdata = '0;
    in_valid = 1'b0; out_ready = 1'b0;
    mode = '0; reg_index = '0; write_data = '0; write_mask = '0;
    in_acc = 1'b0; burst_mode = 1'b0; long_hold_req = 1'b0;
    send_gap = 0; recv_gap = 0; hold_cnt = 0; quiet_cycles = 0;
    n_fail = 0; n_results = 0; n_starts = 0; n_irqs = 0;
    sh_vclk = adfc_pkg::VideoClockReset; sh_cps = adfc_pkg::CountsReset;
    sh_dram = '0; sh_len = '0; sh_ctrl = '0; sh_dac = '0; sh_bits = '0;
    sh_busy = 1'b0; sh_full = 1'b0; sh_dirty = 1'b0; sh_cnt = '0;
    sh_qaddr = '{default: '0}; sh_qlen = '{default: '0}; sh_qdur = '{default: '0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every register, idle ticks, masked writes, queue overwrite,
    // zero-length transfer, unused index and unused mode.
    for (int i = 0; i < 8; i++) queue_access(adfc_pkg::ModeRead, 3'(i), '0, '0);
    queue_access(ModeSpare, adfc_pkg::RegLength, '1, '1);
    queue_access(adfc_pkg::ModeTick, adfc_pkg::RegDram, '0, '0);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegCtrl, '1, '1);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegDram, '1, 32'hFFFF_0000);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegBits, '1, '1);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegDac, 32'd3, '1);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegLength, 32'd8, '1);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegLength, 32'd16, '1);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegLength, 32'd0, '1);
    queue_access(adfc_pkg::ModeRead, adfc_pkg::RegStatus, '0, '0);
    queue_access(adfc_pkg::ModeRead, adfc_pkg::RegLength, '0, '0);
    queue_access(adfc_pkg::ModeWrite, RegSpare, '1, '1);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegStatus, '1, '1);
    wait_drained();
    flush_transfers();
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegLength, 32'd0, '1);
    queue_access(adfc_pkg::ModeTick, adfc_pkg::RegDram, '0, '0);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegBits, '0, '1);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegDac, '0, '1);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegCtrl, '0, '1);
    flush_transfers();

    // Default clocks, mixed idling; the receiver holds off for a long stretch.
    long_hold_req = 1'b1;
    run_random(340, 1'b0);
    flush_transfers();

    set_config(adfc_pkg::CfgCounts, 32'd100);
    burst_mode = 1'b1;
    run_random(340, 1'b0);
    flush_transfers();
    burst_mode = 1'b0;

    set_config(adfc_pkg::CfgVideoClock, '1);
    set_config(adfc_pkg::CfgCounts, 32'd1);
    run_random(340, 1'b0);
    flush_transfers();

    // Extremes last: slow clock gives zero sample rate or oversized quotients,
    // so the unit stays busy and later requests only overwrite the second slot.
    set_config(adfc_pkg::CfgVideoClock, 32'd1);
    set_config(adfc_pkg::CfgCounts, '1);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegDac, '0, '1);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegLength, '1, '1);
    queue_access(adfc_pkg::ModeRead, adfc_pkg::RegLength, '0, '0);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegDac, '1, '1);
    queue_access(adfc_pkg::ModeWrite, adfc_pkg::RegLength, 32'd100, '1);
    run_random(330, 1'b1);
    wait_drained();

    $display("Covered %0d result beats, %0d transfer starts, %0d end interrupts",
             n_results, n_starts, n_irqs);
    $display("across four clock settings, long receiver hold and quiet phases.");
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
